FILE: sv/port_number_allocator_core_macros.svh
// Assertion helpers for the allocator RTL.
`ifndef PORT_NUMBER_ALLOCATOR_CORE_MACROS_SVH
`define PORT_NUMBER_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define PNA_ASSERT_IMP(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset.
`define PNA_ASSERT_NXT(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/pna_pkg.sv
`timescale 1ns / 1ps
package pna_pkg;

  localparam int PORT_BITS  = 16;
  localparam int WORD_W     = 64;
  localparam int BIT_BITS   = 6;                     // bit within a bitmap row
  localparam int ROW_BITS   = PORT_BITS - BIT_BITS;  // 1024 rows
  localparam int ROWS       = 1 << ROW_BITS;
  localparam int MAX_BATCH  = 64;
  localparam int IDX_BITS   = 6;                     // found list index
  localparam int CNT_BITS   = 7;                     // 0 .. MAX_BATCH
  localparam int CFG_IDX_W  = 1;

  localparam logic [PORT_BITS-1:0] RANGE_LOW_RST  = 16'd20002;
  localparam logic [PORT_BITS-1:0] RANGE_HIGH_RST = 16'd65535;

  typedef enum logic [1:0] {
    CMD_TRY     = 2'd0,
    CMD_BATCH   = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_TAKEN    = 3'd1,
    STAT_SHORT    = 3'd2,
    STAT_FREE_REL = 3'd3,
    STAT_TOO_BIG  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_LOW  = 1'b0,
    REG_RANGE_HIGH = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ONE_RD,
    ST_ONE_WR,
    ST_SCAN_RD,
    ST_SCAN_LOAD,
    ST_SCAN_PICK,
    ST_COMMIT_FP,
    ST_COMMIT_RD,
    ST_COMMIT_WR,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic [1:0]           command;
    logic [PORT_BITS-1:0] port;
    logic [15:0]          count;
  } req_t;

  typedef struct packed {
    logic [PORT_BITS-1:0] port_out;
    logic                 port_valid;
    logic [2:0]           status;
    logic                 last;
  } rsp_t;

  typedef struct packed {
    logic valid;
    rsp_t data;
  } emit_t;

endpackage

FILE: sv/pna_engine.sv
`timescale 1ns / 1ps
module pna_engine
  import pna_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  req_t                 req,
  input  logic                 req_take,
  input  logic                 emit_ok,
  input  logic [PORT_BITS-1:0] range_low,
  input  logic [PORT_BITS-1:0] range_high,
  output logic                 idle,
  output emit_t                emit
);

  logic [WORD_W-1:0]    bitmap [ROWS];
  logic [PORT_BITS-1:0] found  [MAX_BATCH];

  state_t               state, state_next;
  logic [ROW_BITS-1:0]  row, row_next;
  logic [CNT_BITS-1:0]  n, n_next;
  logic [CNT_BITS-1:0]  cnt, cnt_next;
  logic [IDX_BITS-1:0]  k, k_next;
  logic [WORD_W-1:0]    free_w, free_next;
  logic [1:0]           cmd_q, cmd_next;
  logic [PORT_BITS-1:0] port_q, port_next;
  logic [2:0]           res_status, stat_next;
  logic [WORD_W-1:0]    bm_q;
  logic [PORT_BITS-1:0] fp_q;

  logic                 bm_re, bm_we, fp_re, fp_we;
  logic [ROW_BITS-1:0]  bm_raddr, bm_waddr;
  logic [WORD_W-1:0]    bm_wdata;

  logic [ROW_BITS-1:0]  lo_row, hi_row;
  logic [WORD_W-1:0]    lo_mask, hi_mask, port_bit, fp_bit, iso;
  logic [BIT_BITS-1:0]  pick_bit;
  logic                 commit_last;

  assign lo_row  = range_low[PORT_BITS-1:BIT_BITS];
  assign hi_row  = range_high[PORT_BITS-1:BIT_BITS];
  assign lo_mask = (row == lo_row) ? ({WORD_W{1'b1}} << range_low[BIT_BITS-1:0])
                                   : {WORD_W{1'b1}};
  assign hi_mask = (row == hi_row)
                   ? ({WORD_W{1'b1}} >> (~range_high[BIT_BITS-1:0]))
                   : {WORD_W{1'b1}};
  assign port_bit = {{(WORD_W-1){1'b0}}, 1'b1} << port_q[BIT_BITS-1:0];
  assign fp_bit   = {{(WORD_W-1){1'b0}}, 1'b1} << fp_q[BIT_BITS-1:0];
  assign commit_last = ((CNT_BITS'(k) + CNT_BITS'(1)) == n);

  // lowest free bit of the working row
  assign iso = free_w & (~free_w + WORD_W'(1));
  always_comb begin
    pick_bit = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (iso[i]) pick_bit = pick_bit | BIT_BITS'(i);
    end
  end

  assign idle = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      row   <= '0;
    end else begin
      state <= state_next;
      row   <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    n          <= n_next;
    cnt        <= cnt_next;
    k          <= k_next;
    free_w     <= free_next;
    cmd_q      <= cmd_next;
    port_q     <= port_next;
    res_status <= stat_next;
  end

  always_ff @(posedge clk) begin
    if (bm_we) bitmap[bm_waddr] <= bm_wdata;
    if (bm_re) bm_q <= bitmap[bm_raddr];
  end

  always_ff @(posedge clk) begin
    if (fp_we) found[n[IDX_BITS-1:0]] <= {row, pick_bit};
    if (fp_re) fp_q <= found[k];
  end

  always_comb begin
    state_next = state;
    row_next   = row;
    n_next     = n;
    cnt_next   = cnt;
    k_next     = k;
    free_next  = free_w;
    cmd_next   = cmd_q;
    port_next  = port_q;
    stat_next  = res_status;
    bm_re      = 1'b0;
    bm_we      = 1'b0;
    bm_raddr   = row;
    bm_waddr   = row;
    bm_wdata   = '0;
    fp_re      = 1'b0;
    fp_we      = 1'b0;
    emit       = '0;

    unique case (state)
      ST_CLEAR: begin
        bm_we    = 1'b1;
        row_next = row + ROW_BITS'(1);
        if (row == {ROW_BITS{1'b1}}) state_next = ST_IDLE;
      end

      ST_IDLE: begin
        if (req_take) begin
          cmd_next  = req.command;
          port_next = req.port;
          unique case (req.command)
            CMD_TRY, CMD_RELEASE: state_next = ST_ONE_RD;
            CMD_BATCH: begin
              priority if (req.count == '0) begin
                stat_next  = STAT_OK;
                state_next = ST_REPORT;
              end else if (req.count > 16'(MAX_BATCH)) begin
                stat_next  = STAT_TOO_BIG;
                state_next = ST_REPORT;
              end else if (range_low > range_high) begin
                stat_next  = STAT_SHORT;
                state_next = ST_REPORT;
              end else begin
                cnt_next   = req.count[CNT_BITS-1:0];
                n_next     = '0;
                row_next   = lo_row;
                state_next = ST_SCAN_RD;
              end
            end
            default: state_next = ST_IDLE;  // unused code: dropped
          endcase
        end
      end

      ST_ONE_RD: begin
        bm_re      = 1'b1;
        bm_raddr   = port_q[PORT_BITS-1:BIT_BITS];
        state_next = ST_ONE_WR;
      end

      ST_ONE_WR: begin
        emit.valid           = 1'b1;
        emit.data.port_out   = port_q;
        emit.data.port_valid = 1'b1;
        emit.data.last       = 1'b1;
        bm_waddr             = port_q[PORT_BITS-1:BIT_BITS];
        if (cmd_q == CMD_TRY) begin
          emit.data.status = (|(bm_q & port_bit)) ? STAT_TAKEN : STAT_OK;
          bm_wdata         = bm_q | port_bit;
        end else begin
          emit.data.status = (|(bm_q & port_bit)) ? STAT_OK : STAT_FREE_REL;
          bm_wdata         = bm_q & ~port_bit;
        end
        if (emit_ok) begin
          bm_we      = 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_SCAN_RD: begin
        bm_re      = 1'b1;
        state_next = ST_SCAN_LOAD;
      end

      ST_SCAN_LOAD: begin
        free_next  = ~bm_q & lo_mask & hi_mask;
        state_next = ST_SCAN_PICK;
      end

      ST_SCAN_PICK: begin
        if (free_w == '0) begin
          if (row == hi_row) begin
            stat_next  = STAT_SHORT;
            state_next = ST_REPORT;
          end else begin
            row_next   = row + ROW_BITS'(1);
            state_next = ST_SCAN_RD;
          end
        end else begin
          fp_we     = 1'b1;
          n_next    = n + CNT_BITS'(1);
          free_next = free_w & ~iso;
          if ((n + CNT_BITS'(1)) == cnt) begin
            k_next     = '0;
            state_next = ST_COMMIT_FP;
          end
        end
      end

      ST_COMMIT_FP: begin
        fp_re      = 1'b1;
        state_next = ST_COMMIT_RD;
      end

      ST_COMMIT_RD: begin
        bm_re      = 1'b1;
        bm_raddr   = fp_q[PORT_BITS-1:BIT_BITS];
        state_next = ST_COMMIT_WR;
      end

      ST_COMMIT_WR: begin
        emit.valid           = 1'b1;
        emit.data.port_out   = fp_q;
        emit.data.port_valid = 1'b1;
        emit.data.status     = STAT_OK;
        emit.data.last       = commit_last;
        bm_waddr             = fp_q[PORT_BITS-1:BIT_BITS];
        bm_wdata             = bm_q | fp_bit;
        if (emit_ok) begin
          bm_we = 1'b1;
          if (commit_last) begin
            state_next = ST_IDLE;
          end else begin
            k_next     = k + IDX_BITS'(1);
            state_next = ST_COMMIT_FP;
          end
        end
      end

      ST_REPORT: begin
        emit.valid       = 1'b1;
        emit.data.status = res_status;
        emit.data.last   = 1'b1;
        if (emit_ok) state_next = ST_IDLE;
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: sv/port_number_allocator_core.sv
// Port number allocator: first-fit bitmap over all 65536 ports.
// Request channel (req_valid / req_stall / req) carries a command, a port and a
// count; response channel (rsp_valid / rsp_stall / rsp) returns port_out,
// port_valid, status and last. A transaction moves when valid is high and
// stall is low. cfg_valid / cfg_ready / cfg_index / cfg_data write range_low
// (index 0) and range_high (index 1); cfg_ready is always high.
// One request is worked on at a time; req_stall stays high until its last
// response has been loaded into the output register.
// Try allocate and release: one read-modify-write of a bitmap row, read in
// ST_ONE_RD and written in ST_ONE_WR as the response register loads.
// Batch allocate: each bitmap row from range_low towards range_high is read
// (ST_SCAN_RD), masked (ST_SCAN_LOAD) and picked one free port at a time
// (ST_SCAN_PICK); then each granted port goes through ST_COMMIT_FP,
// ST_COMMIT_RD and ST_COMMIT_WR. A zero, oversized or inverted-range batch,
// and a failed scan, load one response from ST_REPORT. The bitmap row port
// (one read, one write per cycle) sets the pace. After reset the bitmap is
// cleared one row a cycle, all 1024 rows, while req_stall is high. A stalled
// response holds the output register and the sequencer waits on it.
`timescale 1ns / 1ps
`include "port_number_allocator_core_macros.svh"
module port_number_allocator_core
  import pna_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic [PORT_BITS-1:0] range_low, range_high;
  logic                 eng_idle, req_take, emit_ok;
  emit_t                eng_emit;

  assign cfg_ready = 1'b1;
  assign req_stall = !eng_idle;
  assign req_take  = req_valid && eng_idle;
  assign emit_ok   = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= RANGE_LOW_RST;
      range_high <= RANGE_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RANGE_LOW:  range_low  <= cfg_data[PORT_BITS-1:0];
        REG_RANGE_HIGH: range_high <= cfg_data[PORT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit_ok) begin
      rsp_valid <= eng_emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ok && eng_emit.valid) rsp <= eng_emit.data;
  end

  pna_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .req_take   (req_take),
    .emit_ok    (emit_ok),
    .range_low  (range_low),
    .range_high (range_high),
    .idle       (eng_idle),
    .emit       (eng_emit)
  );

  `PNA_ASSERT_IMP(a_noport_is_last, clk, rst, rsp_valid && !rsp.port_valid, rsp.last, "portless response not final")
  `PNA_ASSERT_IMP(a_error_is_last, clk, rst, rsp_valid && (rsp.status != STAT_OK), rsp.last, "error response not final")
  `PNA_ASSERT_NXT(a_busy_after_cmd, clk, rst, req_valid && !req_stall && (req.command == CMD_TRY || req.command == CMD_BATCH || req.command == CMD_RELEASE), req_stall, "accepted command did not occupy the sequencer")
  `PNA_ASSERT_NXT(a_emit_loads, clk, rst, eng_emit.valid && emit_ok, rsp_valid, "emitted result not registered")

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;
  import pna_pkg::*;

  // the one command code the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  port_number_allocator_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial forever #2 clk = ~clk;

  // predictor state
  bit port_taken_map [0:65535];
  logic [15:0] batch_low = RANGE_LOW_RST;
  logic [15:0] batch_high = RANGE_HIGH_RST;
  rsp_t awaited_rsp[$];

  req_t req_backlog[$];
  int n_queued = 0;
  int n_accepted = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int burst_left;
  int gap_left;
  int hold_asks = 0;
  int holds_served;
  int hold_left;
  int stall_mode;
  int mode_left;
  rsp_t rsp_want;

  function automatic void await_rsp(rsp_t o);
    awaited_rsp.insert(awaited_rsp.size(), o);
  endfunction

  function automatic void predict_responses(req_t r);
    rsp_t o;
    int unsigned grant[$];
    int p;
    o = '0;
    o.last = 1'b1;
    case (r.command)
      CMD_TRY: begin
        o.port_out = r.port;
        o.port_valid = 1'b1;
        o.status = port_taken_map[r.port] ? STAT_TAKEN : STAT_OK;
        port_taken_map[r.port] = 1'b1;
        await_rsp(o);
      end
      CMD_RELEASE: begin
        o.port_out = r.port;
        o.port_valid = 1'b1;
        o.status = port_taken_map[r.port] ? STAT_OK : STAT_FREE_REL;
        port_taken_map[r.port] = 1'b0;
        await_rsp(o);
      end
      CMD_BATCH: begin
        if (r.count == 0) begin
          await_rsp(o);
        end else if (r.count > MAX_BATCH) begin
          o.status = STAT_TOO_BIG;
          await_rsp(o);
        end else begin
          for (p = batch_low; p <= batch_high && grant.size() < r.count; p++)
            if (!port_taken_map[p]) grant.insert(grant.size(), p);
          if (grant.size() < r.count) begin
            o.status = STAT_SHORT;
            await_rsp(o);
          end else begin
            // all or nothing: ports are marked only once the whole batch is found
            foreach (grant[k]) begin
              o.port_out = grant[k];
              o.port_valid = 1'b1;
              o.status = STAT_OK;
              o.last = (k == grant.size() - 1);
              port_taken_map[grant[k]] = 1'b1;
              await_rsp(o);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic queue_req(logic [1:0] cmd, int unsigned port, int unsigned count);
    req_t r;
    r.command = cmd;
    r.port = port[15:0];
    r.count = count[15:0];
    req_backlog.insert(req_backlog.size(), r);
    n_queued++;
  endtask

  // mostly ports near the bottom of the batch range, where batches hand them out
  function automatic int unsigned pick_port();
    int unsigned span;
    if (batch_low > batch_high || $urandom_range(0, 7) == 0) return $urandom_range(0, 65535);
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? 65535 : 0;
    span = batch_high - batch_low;
    if (span > 120) span = 120;
    return batch_low + $urandom_range(0, span);
  endfunction

  task automatic queue_random_req();
    int unsigned sel;
    int unsigned cnt;
    sel = $urandom_range(0, 19);
    case ($urandom_range(0, 19))
      0: cnt = 0;
      1: cnt = $urandom_range(MAX_BATCH + 1, 65535);
      2: cnt = MAX_BATCH;
      3, 4: cnt = $urandom_range(9, MAX_BATCH - 1);
      default: cnt = $urandom_range(1, 8);
    endcase
    if (sel == 0) queue_req(CMD_UNUSED, $urandom_range(0, 65535), $urandom_range(0, 65535));
    else if (sel <= 6) queue_req(CMD_TRY, pick_port(), $urandom_range(0, 65535));
    else if (sel <= 13) queue_req(CMD_RELEASE, pick_port(), $urandom_range(0, 65535));
    else queue_req(CMD_BATCH, $urandom_range(0, 65535), cnt);
  endtask

  // every queued request taken and every response back, then a settling wait
  task automatic wait_drained(int settle);
    do @(posedge clk); while (n_accepted != n_queued || awaited_rsp.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == REG_RANGE_LOW) batch_low = value;
    else batch_high = value;
    cfg_valid <= 1'b0;
  endtask

  // request driver: bursts of random length, random gaps in between
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (req_valid && !req_stall) begin
        predict_responses(req);
        n_accepted++;
      end
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          req <= req_backlog.pop_front();
          req_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 2) == 0) ? 0
                     : $urandom_range(1, ($urandom_range(0, 4) == 0) ? 30 : 6);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response stall pattern, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      holds_served = 0;
      hold_left = 0;
      stall_mode = 0;
      mode_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (holds_served != hold_asks) begin
      holds_served++;
      hold_left = LONG_HOLD - 1;
      rsp_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 3) == 0);
        2: rsp_stall <= ($urandom_range(0, 3) != 0);
        default: rsp_stall <= ~rsp_stall;
      endcase
    end
  end

  // response checker
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_rsp.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected response: port_out=%0d port_valid=%0b status=%0d last=%0b",
                   rsp.port_out, rsp.port_valid, rsp.status, rsp.last);
        mismatches++;
      end else begin
        rsp_want = awaited_rsp.pop_front();
        if (rsp.port_out !== rsp_want.port_out || rsp.port_valid !== rsp_want.port_valid ||
            rsp.status !== rsp_want.status || rsp.last !== rsp_want.last) begin
          if (mismatches < 10)
            $display("response mismatch: expected port_out=%0d port_valid=%0b status=%0d %s",
                     rsp_want.port_out, rsp_want.port_valid, rsp_want.status,
                     $sformatf("last=%0b, got port_out=%0d port_valid=%0b status=%0d last=%0b",
                               rsp_want.last, rsp.port_out, rsp.port_valid, rsp.status,
                               rsp.last));
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles in which no transaction moves
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL port_number_allocator_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset range: taken/free pairs, port extremes, count edges, grant then reuse
    queue_req(CMD_TRY, 20002, 0);
    queue_req(CMD_TRY, 20002, 0);
    queue_req(CMD_RELEASE, 20002, 0);
    queue_req(CMD_RELEASE, 20002, 0);
    queue_req(CMD_TRY, 0, 16'hFFFF);
    queue_req(CMD_TRY, 65535, 0);
    queue_req(CMD_RELEASE, 0, 0);
    queue_req(CMD_RELEASE, 65535, 16'hFFFF);
    queue_req(CMD_BATCH, 0, 0);
    queue_req(CMD_BATCH, 0, MAX_BATCH + 1);
    queue_req(CMD_BATCH, 65535, 65535);
    queue_req(CMD_BATCH, 0, MAX_BATCH);
    queue_req(CMD_BATCH, 0, 1);
    queue_req(CMD_TRY, 20070, 0);
    queue_req(CMD_RELEASE, 20010, 0);
    queue_req(CMD_BATCH, 0, 2);
    queue_req(CMD_UNUSED, 65535, 65535);
    queue_req(CMD_TRY, 16'hAAAA, 16'h5555);
    queue_req(CMD_RELEASE, 16'h5555, 16'hAAAA);
    queue_req(CMD_RELEASE, 16'hAAAA, 0);
    wait_drained(SETTLE_CYCLES);

    // inverted range: nothing can be found
    write_reg(REG_RANGE_LOW, 16'd65535);
    write_reg(REG_RANGE_HIGH, 16'd0);
    queue_req(CMD_BATCH, 0, 1);
    queue_req(CMD_BATCH, 0, MAX_BATCH);
    queue_req(CMD_BATCH, 0, 0);
    queue_req(CMD_BATCH, 0, MAX_BATCH + 1);
    wait_drained(SETTLE_CYCLES);

    // one-port range at the top
    write_reg(REG_RANGE_HIGH, 16'd65535);
    queue_req(CMD_BATCH, 0, 1);
    queue_req(CMD_BATCH, 0, 1);
    queue_req(CMD_RELEASE, 65535, 0);
    queue_req(CMD_BATCH, 0, 2);
    wait_drained(SETTLE_CYCLES);

    // full range, with a long response hold-off while requests keep coming
    write_reg(REG_RANGE_LOW, 16'd0);
    repeat (45) queue_random_req();
    @(posedge clk);
    hold_asks <= hold_asks + 1;
    wait_drained(0);
    repeat (55) queue_random_req();
    wait_drained(SETTLE_CYCLES);

    // narrow range, exhausted often
    write_reg(REG_RANGE_LOW, 16'd100);
    write_reg(REG_RANGE_HIGH, 16'd355);
    repeat (100) queue_random_req();
    @(posedge clk);
    hold_asks <= hold_asks + 1;
    wait_drained(SETTLE_CYCLES);

    write_reg(REG_RANGE_LOW, 16'd0);
    write_reg(REG_RANGE_HIGH, 16'd63);
    repeat (60) queue_random_req();
    wait_drained(32);

    if (awaited_rsp.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("PASS port_number_allocator_core");
    end else begin
      $display("FAIL port_number_allocator_core");
    end
    $finish;
  end

endmodule
